// ===== hw/rtl/energy_meter_reading_scaler_defines.svh =====
// ---------------------------------------------------------------------------
// Energy meter reading scaler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ENERGY_METER_READING_SCALER_DEFINES_SVH
`define ENERGY_METER_READING_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EMRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/emrs_pkg.sv =====
// ---------------------------------------------------------------------------
// Energy meter reading scaler package
// Widths, constants and shared types of the reading scaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package emrs_pkg;

   localparam int DIV_NW = 41;
   localparam int DIV_DW = 34;
   localparam int LAT    = DIV_NW + 1;

   localparam int SEQ_NW = 32;
   localparam int SEQ_DW = 26;

   localparam logic [15:0] COEF_V_RST = 16'd42563;
   localparam logic [15:0] COEF_I_RST = 16'd52241;
   localparam logic [15:0] COEF_P_RST = 16'd44513;
   localparam logic [15:0] COEF_E_RST = 16'd0;

   localparam logic [31:0] VOLT_NUM   = 32'd419430400;
   localparam logic [31:0] CURR_NUM   = 32'd838860800;
   localparam logic [31:0] POWER_NUM  = 32'd2147483648;
   localparam logic [31:0] ENERGY_NUM = 32'd536870912;
   localparam logic [40:0] FREQ_NUM   = 41'd357954500;
   localparam logic [23:0] MIN_CURRENT = 24'd1600;

   localparam logic [1:0] REG_VOLTAGE = 2'd0;
   localparam logic [1:0] REG_CURRENT = 2'd1;
   localparam logic [1:0] REG_POWER   = 2'd2;
   localparam logic [1:0] REG_ENERGY  = 2'd3;

   typedef struct packed {
      logic [15:0] voltage;
      logic [15:0] current;
      logic [15:0] power;
      logic [15:0] energy;
   } coefs_type;

   typedef struct packed {
      logic [28:0] dv;
      logic [33:0] di;
      logic [31:0] dp;
      logic [19:0] de;
   } divisors_type;

   typedef struct packed {
      logic [22:0] eca;
      logic [22:0] ecb;
      logic        per_zero;
   } side_type;

endpackage

// ===== hw/rtl/emrs_pdiv.sv =====
// ---------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emrs_pdiv (
   input  logic                        clock,
   input  logic                        en,
   input  logic [emrs_pkg::DIV_NW-1:0] num,
   input  logic [emrs_pkg::DIV_DW-1:0] den,
   output logic [emrs_pkg::DIV_NW-1:0] quo
);

   localparam int NW = emrs_pkg::DIV_NW;
   localparam int DW = emrs_pkg::DIV_DW;

   logic [DW-1:0] r_ff  [NW-1];
   logic [DW-1:0] d_ff  [NW-1];
   logic [NW-1:0] nq_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW-1:0] r_src;
      logic [DW-1:0] d_src;
      logic [NW-1:0] nq_src;
      logic [DW:0]   t;
      logic          ge;

      if (s == 0) begin : g_first
         assign r_src  = '0;
         assign d_src  = den;
         assign nq_src = num;
      end else begin : g_next
         assign r_src  = r_ff[s-1];
         assign d_src  = d_ff[s-1];
         assign nq_src = nq_ff[s-1];
      end

      assign t  = {r_src, nq_src[NW-1]};
      assign ge = t >= {1'b0, d_src};

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[s] <= {nq_src[NW-2:0], ge};
         end
      end

      if (s < NW - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[s] <= ge ? DW'(t - {1'b0, d_src}) : t[DW-1:0];
               d_ff[s] <= d_src;
            end
         end
      end
   end

   assign quo = nq_ff[NW-1];

endmodule

// ===== hw/rtl/emrs_divisors.sv =====
// ---------------------------------------------------------------------------
// Divisor sequencer
// Derives the four scaling divisors from the coefficients with one serial
// divider, one quotient bit per cycle, and holds them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emrs_divisors (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  emrs_pkg::coefs_type    coefs,
   output logic                   busy,
   output emrs_pkg::divisors_type divs
);

   localparam int NW = emrs_pkg::SEQ_NW;
   localparam int DW = emrs_pkg::SEQ_DW;

   logic          busy_ff;
   logic [1:0]    sel_ff;
   logic [4:0]    cnt_ff;
   logic [DW-1:0] r_ff;
   logic [NW-1:0] nq_ff;
   emrs_pkg::divisors_type divs_ff;

   logic [DW-1:0] den;
   logic [DW:0]   t;
   logic          ge;
   logic [NW-1:0] nq_in;
   logic [NW-1:0] q;
   logic [1:0]    sel_in;
   logic [NW-1:0] numer_in;

   function automatic logic [31:0] numer(input logic [1:0] sel);
      case (sel)
         emrs_pkg::REG_VOLTAGE: numer = emrs_pkg::VOLT_NUM;
         emrs_pkg::REG_CURRENT: numer = emrs_pkg::CURR_NUM;
         emrs_pkg::REG_POWER:   numer = emrs_pkg::POWER_NUM;
         default:               numer = emrs_pkg::ENERGY_NUM;
      endcase
   endfunction

   always_comb begin
      case (sel_ff)
         emrs_pkg::REG_VOLTAGE: den = DW'(coefs.voltage);
         emrs_pkg::REG_CURRENT: den = DW'(coefs.current);
         emrs_pkg::REG_POWER:   den = DW'(coefs.power);
         default:               den = DW'(coefs.energy) * DW'(1000);
      endcase
      t        = {r_ff, nq_ff[NW-1]};
      ge       = t >= {1'b0, den};
      nq_in    = {nq_ff[NW-2:0], ge};
      q        = (den == '0) ? '0 : nq_in;
      sel_in   = sel_ff + 2'd1;
      numer_in = numer(sel_in);
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         sel_ff  <= emrs_pkg::REG_VOLTAGE;
         cnt_ff  <= '0;
         r_ff    <= '0;
         nq_ff   <= emrs_pkg::VOLT_NUM;
      end else if (busy_ff) begin
         if (cnt_ff == 5'd31) begin
            case (sel_ff)
               emrs_pkg::REG_VOLTAGE: divs_ff.dv <= q[28:0];
               emrs_pkg::REG_CURRENT: divs_ff.di <= 34'(q[29:0]) * 34'd10;
               emrs_pkg::REG_POWER:   divs_ff.dp <= q;
               default:               divs_ff.de <= q[19:0];
            endcase
            if (sel_ff == emrs_pkg::REG_ENERGY) begin
               busy_ff <= 1'b0;
            end
            sel_ff <= sel_in;
            cnt_ff <= '0;
            r_ff   <= '0;
            nq_ff  <= numer_in;
         end else begin
            cnt_ff <= cnt_ff + 5'd1;
            r_ff   <= ge ? DW'(t - {1'b0, den}) : t[DW-1:0];
            nq_ff  <= nq_in;
         end
      end
   end

   assign busy = busy_ff;
   assign divs = divs_ff;

endmodule

// ===== hw/rtl/energy_meter_reading_scaler.sv =====
// ---------------------------------------------------------------------------
// Energy meter reading scaler
// Cleans one set of raw metering readings and scales them to units.
// ---------------------------------------------------------------------------
// The block accepts one reading beat per cycle while the output is not stalled
// and the divisors are ready, and returns each result beat through one input
// register stage and the 41-stage pipelined dividers. After reset and after
// every register write, req_tready stays low while one serial divider derives
// the four scaling divisors, one quotient bit per cycle.
`timescale 1ns / 1ps

module energy_meter_reading_scaler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // raw_voltage, raw_period, raw_current_a, raw_power_a, raw_current_b,
   // raw_power_b, raw_energy_a, raw_energy_b
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // voltage_mv, frequency_centihz, current_a_ma, current_b_ma, power_a_mw,
   // power_b_mw, energy_a_wh, energy_b_wh, energy_a_count, energy_b_count,
   // coef_error, zero fill
   output logic [303:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int NW  = emrs_pkg::DIV_NW;
   localparam int DW  = emrs_pkg::DIV_DW;
   localparam int LAT = emrs_pkg::LAT;

   emrs_pkg::coefs_type    coefs_ff;
   emrs_pkg::divisors_type divs;
   logic                   busy;
   logic                   wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.voltage <= emrs_pkg::COEF_V_RST;
         coefs_ff.current <= emrs_pkg::COEF_I_RST;
         coefs_ff.power   <= emrs_pkg::COEF_P_RST;
         coefs_ff.energy  <= emrs_pkg::COEF_E_RST;
      end else if (wr) begin
         case (csr_paddr[3:2])
            emrs_pkg::REG_VOLTAGE: coefs_ff.voltage <= csr_pwdata[15:0];
            emrs_pkg::REG_CURRENT: coefs_ff.current <= csr_pwdata[15:0];
            emrs_pkg::REG_POWER:   coefs_ff.power   <= csr_pwdata[15:0];
            default:               coefs_ff.energy  <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         emrs_pkg::REG_VOLTAGE: csr_prdata = {16'd0, coefs_ff.voltage};
         emrs_pkg::REG_CURRENT: csr_prdata = {16'd0, coefs_ff.current};
         emrs_pkg::REG_POWER:   csr_prdata = {16'd0, coefs_ff.power};
         default:               csr_prdata = {16'd0, coefs_ff.energy};
      endcase
   end

   emrs_divisors u_divs (
      .clock (clock),
      .reset (reset),
      .start (wr),
      .coefs (coefs_ff),
      .busy  (busy),
      .divs  (divs)
   );

   logic adv;
   logic [LAT-1:0] vld_ff;
   emrs_pkg::side_type side_ff [LAT];

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv && !busy;

   logic [23:0] in_v, in_ia, in_ib, in_ea, in_eb;
   logic [15:0] in_per;
   logic [31:0] in_pa, in_pb;
   logic [22:0] volt_c, ia_c, ib_c, ea_c, eb_c;
   logic [14:0] per_c;
   logic [30:0] pa_c, pb_c;

   assign in_v   = req_tdata[23:0];
   assign in_per = req_tdata[39:24];
   assign in_ia  = req_tdata[63:40];
   assign in_pa  = req_tdata[95:64];
   assign in_ib  = req_tdata[119:96];
   assign in_pb  = req_tdata[151:120];
   assign in_ea  = req_tdata[175:152];
   assign in_eb  = req_tdata[199:176];

   function automatic logic [22:0] clean_i(input logic [23:0] v);
      clean_i = (v[23] || v < emrs_pkg::MIN_CURRENT) ? 23'd0 : v[22:0];
   endfunction

   function automatic logic [30:0] mag(input logic [31:0] p);
      logic [31:0] n;
      n = -p;
      if (!p[31]) begin
         mag = p[30:0];
      end else if (n[31]) begin
         mag = '1;
      end else begin
         mag = n[30:0];
      end
   endfunction

   always_comb begin
      volt_c = in_v[23] ? 23'd0 : in_v[22:0];
      per_c  = in_per[15] ? 15'd0 : in_per[14:0];
      ia_c   = clean_i(in_ia);
      ib_c   = clean_i(in_ib);
      pa_c   = (ia_c == '0) ? 31'd0 : mag(in_pa);
      pb_c   = (ib_c == '0) ? 31'd0 : mag(in_pb);
      ea_c   = in_ea[23] ? 23'd0 : in_ea[22:0];
      eb_c   = in_eb[23] ? 23'd0 : in_eb[22:0];
   end

   logic [NW-1:0] v_num_ff, ia_num_ff, ib_num_ff, pa_num_ff, pb_num_ff;
   logic [DW-1:0] per_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid && req_tready};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_num_ff   <= NW'(volt_c) * NW'(1000);
         ia_num_ff  <= NW'(ia_c) * NW'(1000);
         ib_num_ff  <= NW'(ib_c) * NW'(1000);
         pa_num_ff  <= NW'(pa_c) * NW'(1000);
         pb_num_ff  <= NW'(pb_c) * NW'(1000);
         per_den_ff <= DW'({per_c, 3'b000});
         side_ff[0] <= '{eca: ea_c, ecb: eb_c, per_zero: (per_c == '0)};
         for (int k = 1; k < LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic [NW-1:0] q_v, q_f, q_ia, q_ib, q_pa, q_pb, q_ea, q_eb;

   emrs_pdiv u_div_v  (.clock(clock), .en(adv), .num(v_num_ff),
                       .den(DW'(divs.dv)), .quo(q_v));
   emrs_pdiv u_div_f  (.clock(clock), .en(adv), .num(emrs_pkg::FREQ_NUM),
                       .den(per_den_ff), .quo(q_f));
   emrs_pdiv u_div_ia (.clock(clock), .en(adv), .num(ia_num_ff),
                       .den(divs.di), .quo(q_ia));
   emrs_pdiv u_div_ib (.clock(clock), .en(adv), .num(ib_num_ff),
                       .den(divs.di), .quo(q_ib));
   emrs_pdiv u_div_pa (.clock(clock), .en(adv), .num(pa_num_ff),
                       .den(DW'(divs.dp)), .quo(q_pa));
   emrs_pdiv u_div_pb (.clock(clock), .en(adv), .num(pb_num_ff),
                       .den(DW'(divs.dp)), .quo(q_pb));
   emrs_pdiv u_div_ea (.clock(clock), .en(adv), .num(NW'(side_ff[0].eca)),
                       .den(DW'(divs.de)), .quo(q_ea));
   emrs_pdiv u_div_eb (.clock(clock), .en(adv), .num(NW'(side_ff[0].ecb)),
                       .den(DW'(divs.de)), .quo(q_eb));

   logic zv, zi, zp, ze, zf;

   always_comb begin
      zv = divs.dv == '0;
      zi = divs.di == '0;
      zp = divs.dp == '0;
      ze = divs.de == '0;
      zf = side_ff[LAT-1].per_zero;
      rsp_tdata            = '0;
      rsp_tdata[32:0]      = zv ? 33'd0 : q_v[32:0];
      rsp_tdata[58:33]     = zf ? 26'd0 : q_f[25:0];
      rsp_tdata[91:59]     = zi ? 33'd0 : q_ia[32:0];
      rsp_tdata[124:92]    = zi ? 33'd0 : q_ib[32:0];
      rsp_tdata[165:125]   = zp ? 41'd0 : q_pa;
      rsp_tdata[206:166]   = zp ? 41'd0 : q_pb;
      rsp_tdata[229:207]   = ze ? 23'd0 : q_ea[22:0];
      rsp_tdata[252:230]   = ze ? 23'd0 : q_eb[22:0];
      rsp_tdata[275:253]   = side_ff[LAT-1].eca;
      rsp_tdata[298:276]   = side_ff[LAT-1].ecb;
      rsp_tdata[299]       = zv || zi || zp || ze;
   end

   assign rsp_tvalid = vld_ff[LAT-1];

endmodule

// ===== hw/rtl/emrs_checker.sv =====
// ---------------------------------------------------------------------------
// Energy meter reading scaler checker
// Port-level assertions on the reading scaler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "energy_meter_reading_scaler_defines.svh"

module emrs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [199:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [303:0] rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite,
   input logic [3:0]   csr_paddr,
   input logic [31:0]  csr_pwdata,
   input logic [31:0]  csr_prdata,
   input logic         csr_pready
);

   `EMRS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `EMRS_ASSERT_NOW(a_pready, 1'b1, csr_pready)
   `EMRS_ASSERT_NOW(a_busy_after_reset, $fell(reset), !req_tready)
   `EMRS_ASSERT_NEXT(a_busy_after_write, csr_psel && csr_penable && csr_pwrite, !req_tready)

endmodule

bind energy_meter_reading_scaler emrs_checker u_emrs_checker (.*);
